// ===== rtl/ek_pkg.sv =====
// Shared constants, tables and helpers for the elliptic integral K pipeline.
`default_nettype none

package ek_pkg;

    localparam int FRAC_BITS_DEF = 24;

    // Internal fixed point: unsigned with WB fraction bits.
    localparam int WB     = 29;
    localparam int X_W    = WB + 1;
    localparam int ACC_W  = WB + 2;
    localparam int NL_W   = 36;

    localparam int POLY_N = 11;
    localparam int SER_N  = 8;

    // Divider for the atanh argument: quotient bits and bits per stage.
    localparam int DIV_BITS   = WB - 1;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    // Cycles from the logarithm unit's input to its registered output.
    localparam int LOG_LAT = DIV_STAGES + SER_N + 5;

    localparam longint unsigned DEC_UNIT = 64'd1000000000;

    typedef longint unsigned t_dec_tab [POLY_N];

    localparam t_dec_tab P_DEC = '{
        64'd1386294361119890625, 64'd96573590281169013, 64'd30885146524671200,
        64'd14938044891680525, 64'd8790782739527438, 64'd6189010336376876,
        64'd6874896874499499, 64'd9858213790212260, 64'd7974040132204152,
        64'd2280257240058756, 64'd137982864606273
    };

    localparam t_dec_tab Q_DEC = '{
        64'd500000000000000000, 64'd124999999999870820, 64'd70312499696395747,
        64'd48828034757099824, 64'd37377431417382323, 64'd30120471522760405,
        64'd23908960271592489, 64'd15485051664976240, 64'd5940583037531678,
        64'd914184723865917, 64'd29407895504860
    };

    localparam longint unsigned LN4_DEC = 64'd1386294361119890619;
    localparam longint unsigned LN2_DEC = 64'd693147180559945309;

    // Rounded reciprocals 1/17, 1/15, ... 1/1 in Q.WB for the atanh series.
    typedef logic [X_W-1:0] t_recip_tab [SER_N+1];

    localparam t_recip_tab RECIP = '{
        30'd31580642, 30'd35791394, 30'd41297762, 30'd48806447, 30'd59652324,
        30'd76695845, 30'd107374182, 30'd178956971, 30'd536870912
    };

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_DOMAIN   = 2'd1,
        ST_INFINITE = 2'd2
    } t_status;

    // Decimal value with 18 fraction digits to Q.WB, rounded to nearest.
    function automatic longint unsigned dec_to_fix(input longint unsigned d);
        longint unsigned hi;
        longint unsigned lo;
        hi = d / DEC_UNIT;
        lo = d % DEC_UNIT;
        return ((hi << WB) + ((lo << WB) / DEC_UNIT) + DEC_UNIT / 2) / DEC_UNIT;
    endfunction

    // Rescale a Q.2WB product to Q.WB, rounding ties up.
    function automatic logic [63:0] round_q(input logic [63:0] p);
        return (p + (64'd1 << (WB - 1))) >> WB;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ek_horner.sv =====
// Pipelined Horner evaluation of a degree-10 polynomial, one coefficient per stage.
`default_nettype none

module ek_horner
    import ek_pkg::*;
#(
    parameter t_dec_tab COEFS = P_DEC
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [X_W-1:0]   i_x,
    output logic [ACC_W-1:0] o_acc
);

    localparam int NS = POLY_N - 1;
    localparam logic [ACC_W-1:0] C_LEAD = ACC_W'(dec_to_fix(COEFS[POLY_N-1]));

    logic [ACC_W-1:0] r_acc [NS];
    logic [X_W-1:0]   r_x   [NS-1];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic [ACC_W-1:0] C_I = ACC_W'(dec_to_fix(COEFS[NS-1-i]));
        logic [ACC_W-1:0]     w_acc;
        logic [X_W-1:0]       w_x;
        logic [ACC_W+X_W-1:0] w_p;

        if (i == 0) begin : g_first
            assign w_acc = C_LEAD;
            assign w_x   = i_x;
        end else begin : g_next
            assign w_acc = r_acc[i-1];
            assign w_x   = r_x[i-1];
        end

        assign w_p = w_acc * w_x;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[i] <= ACC_W'(round_q(64'(w_p))) + C_I;
            end
        end

        if (i < NS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i] <= w_x;
                end
            end
        end
    end

    assign o_acc = r_acc[NS-1];

endmodule

`default_nettype wire

// ===== rtl/ek_log.sv =====
// Pipelined -ln(code * 2^-FRAC_BITS): normalize, divide, atanh series.
`default_nettype none

module ek_log
    import ek_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [FRAC_BITS:0]  i_code,
    output logic [NL_W-1:0]     o_neg_ln
);

    localparam int CW = FRAC_BITS + 1;
    localparam int EW = $clog2(CW);
    localparam int RW = WB + 3;
    localparam int ND = DIV_STAGES;
    localparam int BD = DIV_STAGES + SER_N + 2;
    localparam logic [RW-1:0]   ONE_R   = RW'(1) << WB;
    localparam logic [NL_W-1:0] LN2_FIX = NL_W'(dec_to_fix(LN2_DEC));

    // Stage 1: exponent of the leading one.
    logic [EW-1:0] n_e;
    logic [CW-1:0] r_code;
    logic [EW-1:0] r_e;

    always_comb begin
        n_e = '0;
        for (int i = 1; i < CW; i++) begin
            if (i_code[i]) begin
                n_e = EW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_code <= i_code;
            r_e    <= n_e;
        end
    end

    // Stage 2: mantissa in [1,2), divider operands and the exponent term.
    logic [CW+WB-1:0] w_sh;
    logic [WB-1:0]    w_mf;
    logic [EW:0]      w_ediff;
    logic [NL_W-1:0]  w_base;

    assign w_sh    = {r_code, {WB{1'b0}}} >> r_e;
    assign w_mf    = w_sh[WB-1:0];
    assign w_ediff = (EW + 1)'(FRAC_BITS) - (EW + 1)'(r_e);
    assign w_base  = NL_W'(w_ediff) * LN2_FIX;

    logic [RW-1:0]       r_rem  [ND+1];
    logic [RW-1:0]       r_den  [ND+1];
    logic [DIV_BITS-1:0] r_q    [ND+1];
    logic [NL_W-1:0]     r_base [BD+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'({w_mf, 1'b0});
            r_den[0]  <= RW'({1'b1, w_mf}) + ONE_R;
            r_q[0]    <= '0;
            r_base[0] <= w_base;
            for (int k = 1; k <= BD; k++) begin
                r_base[k] <= r_base[k-1];
            end
        end
    end

    // Restoring division (m-1)/(m+1), a few quotient bits per stage.
    for (genvar d = 0; d < ND; d++) begin : g_div
        logic [RW-1:0]       n_rem;
        logic [DIV_BITS-1:0] n_q;

        always_comb begin
            logic [RW-1:0]       v_rem;
            logic [DIV_BITS-1:0] v_q;
            v_rem = r_rem[d];
            v_q   = r_q[d];
            for (int b = 0; b < DIV_STEP; b++) begin
                v_rem = {v_rem[RW-2:0], 1'b0};
                if (v_rem >= r_den[d]) begin
                    v_rem = v_rem - r_den[d];
                    v_q   = {v_q[DIV_BITS-2:0], 1'b1};
                end else begin
                    v_q   = {v_q[DIV_BITS-2:0], 1'b0};
                end
            end
            n_rem = v_rem;
            n_q   = v_q;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[d+1] <= n_rem;
                r_den[d+1] <= r_den[d];
                r_q[d+1]   <= n_q;
            end
        end
    end

    // Square of the series argument.
    logic [2*DIV_BITS-1:0] w_ss;
    logic [DIV_BITS-1:0]   r_sv  [SER_N+1];
    logic [DIV_BITS-1:0]   r_s2v [SER_N];
    logic [X_W-1:0]        r_t   [SER_N];

    assign w_ss = r_q[ND] * r_q[ND];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv[0]  <= r_q[ND];
            r_s2v[0] <= DIV_BITS'(round_q(64'(w_ss)));
        end
    end

    // Odd-power atanh series by Horner, one term per stage.
    for (genvar j = 0; j < SER_N; j++) begin : g_ser
        logic [X_W-1:0]          w_t;
        logic [X_W+DIV_BITS-1:0] w_p;

        if (j == 0) begin : g_first
            assign w_t = RECIP[0];
        end else begin : g_next
            assign w_t = r_t[j-1];
        end

        assign w_p = w_t * r_s2v[j];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[j]    <= X_W'(round_q(64'(w_p))) + RECIP[j+1];
                r_sv[j+1] <= r_sv[j];
            end
        end

        if (j < SER_N - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s2v[j+1] <= r_s2v[j];
                end
            end
        end
    end

    // ln of the mantissa, then subtract it from the exponent term.
    logic [DIV_BITS+X_W:0] w_lp;
    logic [WB+1:0]         r_lnm;
    logic [NL_W-1:0]       r_nl;

    assign w_lp = {r_sv[SER_N], 1'b0} * r_t[SER_N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lnm <= (WB + 2)'(round_q(64'(w_lp)));
            if (r_base[BD] > NL_W'(r_lnm)) begin
                r_nl <= r_base[BD] - NL_W'(r_lnm);
            end else begin
                r_nl <= '0;
            end
        end
    end

    assign o_neg_ln = r_nl;

endmodule

`default_nettype wire

// ===== rtl/elliptic_integral_k.sv =====
// Top level of the complete elliptic integral of the first kind, K(m).
`default_nettype none

// Takes one word per clock, x = 1 - m in signed Q1.FRAC_BITS, and returns K(m) in
// unsigned Q4.FRAC_BITS with a status code. The pipeline depth is set by the
// logarithm path: leading-one search and normalization, a restoring divider
// giving four quotient bits per stage, and an eight-stage atanh series; the two
// degree-10 polynomials run beside it, one Horner step per stage. Throughput is
// one word per cycle with no gaps while the output word is not held. When the
// output word is held by i_stall, the whole pipeline holds and o_stall rises so
// the next input word waits; nothing is dropped or repeated. Arguments below
// zero or above one give 0 with a domain status, zero gives the saturated maximum
// with an infinity status, and the smallest positive code uses ln4 - ln(x)/2.
module elliptic_integral_k
    import ek_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [FRAC_BITS+1:0] i_argument,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [FRAC_BITS+3:0]      o_integral_value,
    output logic [1:0]                o_status
);

    localparam int IN_W  = FRAC_BITS + 2;
    localparam int OW    = FRAC_BITS + 4;
    localparam int SH_UP = (FRAC_BITS < WB) ? WB - FRAC_BITS : 0;
    localparam int SH_DN = (FRAC_BITS > WB) ? FRAC_BITS - WB : 0;
    localparam int LAT   = LOG_LAT + 3;
    localparam int HD    = LOG_LAT - (POLY_N - 1);
    localparam int YW    = NL_W + 2;
    localparam int VW    = YW + SH_DN;
    localparam logic [IN_W-1:0] ONE_IN  = IN_W'(1) << FRAC_BITS;
    localparam logic [OW-1:0]   OUT_MAX = '1;
    localparam logic [YW-1:0]   LN4_FIX = YW'(dec_to_fix(LN4_DEC));

    typedef struct packed {
        logic dom;
        logic zero;
        logic one;
    } t_flags;

    // The pipeline advances as one unit unless the output word is held.
    logic w_en;
    logic [LAT-1:0] r_vld;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = r_vld[LAT-1] && i_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Classify the argument and bring it to the internal Q.WB scale.
    logic [IN_W-1:0] w_raw;
    t_flags          w_fl;
    logic [X_W-1:0]  w_x;

    assign w_raw     = $unsigned(i_argument);
    assign w_fl.dom  = w_raw > ONE_IN;
    assign w_fl.zero = w_raw == '0;
    assign w_fl.one  = w_raw == IN_W'(1);

    if (SH_DN > 0) begin : g_xdn
        logic [IN_W-1:0] w_xr;
        assign w_xr = w_raw + (IN_W'(1) << (SH_DN - 1));
        assign w_x  = X_W'(w_xr >> SH_DN);
    end else begin : g_xup
        assign w_x = X_W'(w_raw[FRAC_BITS:0]) << SH_UP;
    end

    // Side chain: status flags for the whole depth, x until the polynomials start.
    t_flags         r_fl [LOG_LAT+2];
    logic [X_W-1:0] r_x  [HD];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fl[0] <= w_fl;
            for (int k = 1; k < LOG_LAT + 2; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
            r_x[0] <= w_x;
            for (int k = 1; k < HD; k++) begin
                r_x[k] <= r_x[k-1];
            end
        end
    end

    logic [NL_W-1:0]  w_nl;
    logic [ACC_W-1:0] w_pacc;
    logic [ACC_W-1:0] w_qacc;

    ek_log #(
        .FRAC_BITS(FRAC_BITS)
    ) u_log (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_code   (w_raw[FRAC_BITS:0]),
        .o_neg_ln (w_nl)
    );

    ek_horner #(
        .COEFS(P_DEC)
    ) u_hp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_x[HD-1]),
        .o_acc (w_pacc)
    );

    ek_horner #(
        .COEFS(Q_DEC)
    ) u_hq (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_x[HD-1]),
        .o_acc (w_qacc)
    );

    // -ln(x) * Q(x), split so each multiplier stays near 32 bits.
    logic [WB+ACC_W-1:0]        w_pl;
    logic [NL_W-WB+ACC_W-1:0]   w_ph;
    logic [WB+ACC_W-1:0]        r_pl;
    logic [NL_W-WB+ACC_W-1:0]   r_ph;
    logic [ACC_W-1:0]           r_p;
    logic [NL_W-1:0]            r_nl;

    assign w_pl = w_nl[WB-1:0] * w_qacc;
    assign w_ph = w_nl[NL_W-1:WB] * w_qacc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pl <= w_pl;
            r_ph <= w_ph;
            r_p  <= w_pacc;
            r_nl <= w_nl;
        end
    end

    // Sum in Q.WB; the smallest positive code takes ln4 plus half of -ln(x).
    logic [NL_W:0]   w_nlr;
    logic [YW-1:0]   r_y;

    assign w_nlr = (NL_W + 1)'(r_nl) + (NL_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_fl[LOG_LAT].one) begin
                r_y <= LN4_FIX + YW'(w_nlr >> 1);
            end else begin
                r_y <= YW'(r_p) + YW'(r_ph) + YW'(round_q(64'(r_pl)));
            end
        end
    end

    // Back to Q.FRAC_BITS, saturate, and apply the special cases.
    logic [VW-1:0] w_v;
    logic [OW-1:0] w_sat;
    logic [OW-1:0] r_value;
    t_status       r_status;

    if (SH_UP > 0) begin : g_vdn
        assign w_v = VW'((r_y + (YW'(1) << (SH_UP - 1))) >> SH_UP);
    end else begin : g_vup
        assign w_v = VW'(r_y) << SH_DN;
    end

    assign w_sat = (w_v > VW'(OUT_MAX)) ? OUT_MAX : w_v[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_fl[LOG_LAT+1].dom) begin
                r_value  <= '0;
                r_status <= ST_DOMAIN;
            end else if (r_fl[LOG_LAT+1].zero) begin
                r_value  <= OUT_MAX;
                r_status <= ST_INFINITE;
            end else begin
                r_value  <= w_sat;
                r_status <= ST_NORMAL;
            end
        end
    end

    assign o_integral_value = r_value;
    assign o_status         = r_status;

endmodule

`default_nettype wire

// ===== rtl/ek_chk.sv =====
// Port-level checker for the elliptic integral K block, bound to the top level.
`default_nettype none

module ek_chk
    import ek_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic signed [FRAC_BITS+1:0] i_argument,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [FRAC_BITS+3:0]        o_integral_value,
    input logic [1:0]                  o_status
);

    // A domain error always reports a zero value.
    a_domain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DOMAIN |-> o_integral_value == '0)
        else $error("domain error word carries a nonzero value");

    // An infinite result is saturated to all ones.
    a_inf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INFINITE |-> &o_integral_value)
        else $error("infinite result is not saturated");

    // A held output word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_integral_value)
                               && $stable(o_status))
        else $error("held output word changed");

    // Input back-pressure only comes from a held output word.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output word");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

endmodule

bind elliptic_integral_k ek_chk #(.FRAC_BITS(FRAC_BITS)) u_ek_chk (.*);

`default_nettype wire
